// File: hdl/sexp_tok_pkg.sv
package sexp_tok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ATOM,
    MODE_STR,
    MODE_ESC,
    MODE_CMT
  } mode_e;

  typedef enum logic [3:0] {
    EV_LPAREN,
    EV_RPAREN,
    EV_LBRACK,
    EV_RBRACK,
    EV_LBRACE,
    EV_RBRACE,
    EV_VALUE,
    EV_TEND,
    EV_EOF
  } ev_e;

  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_STR,
    CLS_SYM
  } cls_e;

  typedef enum logic [4:0] {
    R_START, R_SIGN, R_ZERO, R_INT, R_DOTN, R_FRAC, R_EXPE, R_EXPS, R_EXPD,
    R_HX, R_HINT, R_HDOTN, R_HFRAC, R_HP, R_HPS, R_HPD,
    R_I, R_IN, R_INF, R_INFI, R_INFIN, R_INFINI, R_INFINIT, R_INFINITY,
    R_N, R_NA, R_NAN, R_DEAD
  } rec_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  // one run: every result caused by one source byte, up to three
  typedef struct packed {
    logic [1:0] cnt;
    ev_e        ev0;
    ev_e        ev1;
    ev_e        ev2;
    logic [7:0] ch;
    cls_e       cls;
  } run_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  function automatic logic is_ws(logic [7:0] c);
    return (c inside {[CH_TAB:8'h0D]}) || (c == CH_SPACE);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_bracket(logic [7:0] c);
    return c inside {"(", ")", "[", "]", "{", "}"};
  endfunction

  function automatic ev_e bracket_ev(logic [7:0] c);
    ev_e e;
    case (c)
      "(":     e = EV_LPAREN;
      ")":     e = EV_RPAREN;
      "[":     e = EV_LBRACK;
      "]":     e = EV_RBRACK;
      "{":     e = EV_LBRACE;
      default: e = EV_RBRACE;
    endcase
    return e;
  endfunction

  function automatic logic rec_accepting(rec_e r);
    return r inside {R_ZERO, R_INT, R_FRAC, R_EXPD, R_HINT, R_HFRAC, R_HPD,
                     R_INF, R_INFINITY, R_NAN};
  endfunction

  // mantissa start: shared by the start and after-sign positions
  function automatic rec_e rec_lead(logic [7:0] c, logic [7:0] lc);
    rec_e r;
    if (c == "0")       r = R_ZERO;
    else if (is_dig(c)) r = R_INT;
    else if (c == ".")  r = R_DOTN;
    else if (lc == "i") r = R_I;
    else if (lc == "n") r = R_N;
    else                r = R_DEAD;
    return r;
  endfunction

  function automatic rec_e rec_int(logic [7:0] c, logic [7:0] lc);
    rec_e r;
    if (is_dig(c))      r = R_INT;
    else if (c == ".")  r = R_FRAC;
    else if (lc == "e") r = R_EXPE;
    else                r = R_DEAD;
    return r;
  endfunction

  function automatic rec_e rec_step(rec_e r, logic [7:0] c);
    logic [7:0] lc;
    logic       d;
    logic       sg;
    rec_e       nx;
    lc = to_lower(c);
    d  = is_dig(c);
    sg = (c == "+") || (c == "-");
    case (r)
      R_START:    nx = sg ? R_SIGN : rec_lead(c, lc);
      R_SIGN:     nx = rec_lead(c, lc);
      R_ZERO:     nx = (lc == "x") ? R_HX : rec_int(c, lc);
      R_INT:      nx = rec_int(c, lc);
      R_DOTN:     nx = d ? R_FRAC : R_DEAD;
      R_FRAC:     nx = d ? R_FRAC : ((lc == "e") ? R_EXPE : R_DEAD);
      R_EXPE:     nx = sg ? R_EXPS : (d ? R_EXPD : R_DEAD);
      R_EXPS,
      R_EXPD:     nx = d ? R_EXPD : R_DEAD;
      R_HX:       nx = is_hex(c) ? R_HINT : ((c == ".") ? R_HDOTN : R_DEAD);
      R_HINT: begin
        if (is_hex(c))      nx = R_HINT;
        else if (c == ".")  nx = R_HFRAC;
        else if (lc == "p") nx = R_HP;
        else                nx = R_DEAD;
      end
      R_HDOTN:    nx = is_hex(c) ? R_HFRAC : R_DEAD;
      R_HFRAC:    nx = is_hex(c) ? R_HFRAC : ((lc == "p") ? R_HP : R_DEAD);
      R_HP:       nx = sg ? R_HPS : (d ? R_HPD : R_DEAD);
      R_HPS,
      R_HPD:      nx = d ? R_HPD : R_DEAD;
      R_I:        nx = (lc == "n") ? R_IN : R_DEAD;
      R_IN:       nx = (lc == "f") ? R_INF : R_DEAD;
      R_INF:      nx = (lc == "i") ? R_INFI : R_DEAD;
      R_INFI:     nx = (lc == "n") ? R_INFIN : R_DEAD;
      R_INFIN:    nx = (lc == "i") ? R_INFINI : R_DEAD;
      R_INFINI:   nx = (lc == "t") ? R_INFINIT : R_DEAD;
      R_INFINIT:  nx = (lc == "y") ? R_INFINITY : R_DEAD;
      R_N:        nx = (lc == "a") ? R_NA : R_DEAD;
      R_NA:       nx = (lc == "n") ? R_NAN : R_DEAD;
      default:    nx = R_DEAD;
    endcase
    return nx;
  endfunction

endpackage

// File: hdl/s_expression_tokenizer.sv
// Streaming S-expression tokenizer.
// Input channel: one source byte per transfer (in_valid_i / in_stall_o);
// byte 0 ends the source, closes any open token, reports end of file and
// returns the lexer to idle.
// Output channel: one event per transfer (out_valid_o / out_stall_i):
// brackets, decoded value characters, token end with its class, and end
// of file. A byte causes zero to three events; last_of_run_o marks the
// final one.
// Events of a byte are written into the run queue when it transfers and are offered
// from the queue head. One byte per cycle is taken while in_stall_o is low; the output
// moves one event per cycle while out_stall_i is low, so a byte holds it for each event.
// A 4-entry run queue sits between the lexer and the output sequencer;
// in_stall_o rises only when that queue is full.
// Reset: lexer idle, number recognizer at start of atom, queue empty.
// While out_stall_i is high the offered event holds unchanged.
module s_expression_tokenizer import sexp_tok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] event_res_o,
  output logic [7:0] value_char_o,
  output logic [1:0] token_class_o,
  output logic       last_of_run_o
);

  logic q_push, q_pop, q_full, q_empty;
  run_t q_wdata, q_rdata;

  sexp_tok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .source_byte_i(source_byte_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  sexp_tok_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  sexp_tok_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_rdata),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .value_char_o (value_char_o),
    .token_class_o(token_class_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// File: hdl/sexp_tok_front.sv
module sexp_tok_front import sexp_tok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output run_t       q_data_o
);

  mode_e mode_q, mode_d;
  rec_e  rec_q, rec_d;
  run_t  run;
  logic  accept;
  logic  term;
  logic  br;
  logic [7:0] c;

  assign c          = source_byte_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign br         = is_bracket(c);
  assign term       = (c == CH_NUL) || is_ws(c) || br || (c == CH_SEMI);

  always_comb begin
    mode_d = mode_q;
    rec_d  = rec_q;
    case (mode_q)
      MODE_ATOM: begin
        if (term) begin
          rec_d  = R_START;
          mode_d = (c == CH_SEMI) ? MODE_CMT : MODE_IDLE;
        end else begin
          rec_d = rec_step(rec_q, c);
        end
      end
      MODE_STR: begin
        if (c == CH_NUL || c == CH_QUOTE) mode_d = MODE_IDLE;
        else if (c == CH_BSLASH)          mode_d = MODE_ESC;
      end
      MODE_ESC: mode_d = (c == CH_NUL) ? MODE_IDLE : MODE_STR;
      MODE_CMT: begin
        if (c == CH_NUL || c == CH_LF) mode_d = MODE_IDLE;
      end
      default: begin
        // idle
        mode_d = MODE_IDLE;
        rec_d  = R_START;
        if (c == CH_NUL || is_ws(c) || br) begin
          mode_d = MODE_IDLE;
        end else if (c == CH_SEMI) begin
          mode_d = MODE_CMT;
        end else if (c == CH_QUOTE) begin
          mode_d = MODE_STR;
        end else begin
          rec_d  = rec_step(R_START, c);
          mode_d = MODE_ATOM;
        end
      end
    endcase
  end

  always_comb begin
    run     = '0;
    run.ev0 = EV_VALUE;
    run.ev1 = EV_EOF;
    run.ev2 = EV_EOF;
    run.ch  = c;
    run.cls = CLS_STR;
    case (mode_q)
      MODE_ATOM: begin
        if (term) begin
          run.ev0 = EV_TEND;
          run.cls = rec_accepting(rec_q) ? CLS_NUM : CLS_SYM;
          run.cnt = 2'd1;
          if (br) begin
            run.ev1 = bracket_ev(c);
            run.cnt = 2'd2;
          end else if (c == CH_NUL) begin
            run.cnt = 2'd2;
          end
        end else begin
          run.cnt = 2'd1;
        end
      end
      MODE_STR: begin
        if (c == CH_NUL) begin
          run.ev0 = EV_TEND;
          run.cnt = 2'd2;
        end else if (c == CH_QUOTE) begin
          run.ev0 = EV_TEND;
          run.cnt = 2'd1;
        end else if (c != CH_BSLASH) begin
          run.cnt = 2'd1;
        end
      end
      MODE_ESC: begin
        run.cnt = 2'd1;
        if (c == CH_NUL) begin
          // lone backslash at end of source
          run.ch  = CH_BSLASH;
          run.ev1 = EV_TEND;
          run.cnt = 2'd3;
        end else if (c == CH_LC_N) begin
          run.ch = CH_LF;
        end else if (c == CH_LC_T) begin
          run.ch = CH_TAB;
        end
      end
      MODE_CMT: begin
        if (c == CH_NUL) begin
          run.ev0 = EV_EOF;
          run.cnt = 2'd1;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          run.ev0 = EV_EOF;
          run.cnt = 2'd1;
        end else if (br) begin
          run.ev0 = bracket_ev(c);
          run.cnt = 2'd1;
        end else if (!is_ws(c) && c != CH_SEMI && c != CH_QUOTE) begin
          run.cnt = 2'd1;
        end
      end
    endcase
  end

  assign q_push_o = accept && (run.cnt != 2'd0);
  assign q_data_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      rec_q  <= R_START;
    end else if (accept) begin
      mode_q <= mode_d;
      rec_q  <= rec_d;
    end
  end

endmodule

// File: hdl/sexp_tok_queue.sv
module sexp_tok_queue import sexp_tok_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t wdata_i,
  input  logic pop_i,
  output run_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  run_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// File: hdl/sexp_tok_back.sv
module sexp_tok_back import sexp_tok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] event_res_o,
  output logic [7:0] value_char_o,
  output logic [1:0] token_class_o,
  output logic       last_of_run_o
);

  logic [1:0] idx_q, idx_d;
  ev_e        ev;
  logic       last;
  logic       xfer;

  always_comb begin
    case (idx_q)
      2'd0:    ev = head_i.ev0;
      2'd1:    ev = head_i.ev1;
      default: ev = head_i.ev2;
    endcase
  end

  assign last          = (idx_q == head_i.cnt - 2'd1);
  assign out_valid_o   = !empty_i;
  assign xfer          = out_valid_o && !out_stall_i;
  assign pop_o         = xfer && last;
  assign event_res_o   = ev;
  assign value_char_o  = (ev == EV_VALUE) ? head_i.ch : 8'd0;
  assign token_class_o = (ev == EV_TEND) ? head_i.cls : CLS_NUM;
  assign last_of_run_o = last;

  // advance through the run, restart on the next entry
  always_comb begin
    idx_d = idx_q;
    if (xfer) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: tb/sv/sexp_tok_checker.sv
module sexp_tok_checker import sexp_tok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] source_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [3:0] event_res_i,
  input  logic [7:0] value_char_i,
  input  logic [1:0] token_class_i,
  input  logic       last_of_run_i,
  output int         fail_cnt_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_e        ev;
    logic [7:0] ch;
    cls_e       cls;
    logic       last;
  } lex_event_t;

  lex_event_t awaited_events[$];
  lex_event_t run_buf[$];
  lex_event_t head;
  mode_e      lex_mode;
  rec_e       num_pos;
  int         fails;

  function automatic logic blank_char(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic hex_char(logic [7:0] c);
    return digit_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
  endfunction

  function automatic logic delim_bracket(logic [7:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic ev_e bracket_code_of(logic [7:0] c);
    ev_e e;
    case (c)
      "(":     e = EV_LPAREN;
      ")":     e = EV_RPAREN;
      "[":     e = EV_LBRACK;
      "]":     e = EV_RBRACK;
      "{":     e = EV_LBRACE;
      default: e = EV_RBRACE;
    endcase
    return e;
  endfunction

  function automatic logic numeral_complete(rec_e p);
    logic ok;
    case (p)
      R_ZERO, R_INT, R_FRAC, R_EXPD, R_HINT, R_HFRAC, R_HPD,
      R_INF, R_INFINITY, R_NAN: ok = 1'b1;
      default:                  ok = 1'b0;
    endcase
    return ok;
  endfunction

  // strtod acceptance, one atom character at a time
  function automatic rec_e numeral_advance(rec_e p, logic [7:0] c);
    logic [7:0] lc;
    logic       dg;
    logic       sg;
    rec_e       q;
    lc = fold_case(c);
    dg = digit_char(c);
    sg = (c == "+") || (c == "-");
    q  = R_DEAD;
    case (p)
      R_START, R_SIGN: begin
        if (p == R_START && sg) q = R_SIGN;
        else if (c == "0")      q = R_ZERO;
        else if (dg)            q = R_INT;
        else if (c == ".")      q = R_DOTN;
        else if (lc == "i")     q = R_I;
        else if (lc == "n")     q = R_N;
      end
      R_ZERO, R_INT: begin
        if (p == R_ZERO && lc == "x") q = R_HX;
        else if (dg)                  q = R_INT;
        else if (c == ".")            q = R_FRAC;
        else if (lc == "e")           q = R_EXPE;
      end
      R_DOTN: begin
        if (dg) q = R_FRAC;
      end
      R_FRAC: begin
        if (dg)             q = R_FRAC;
        else if (lc == "e") q = R_EXPE;
      end
      R_EXPE: begin
        if (sg)      q = R_EXPS;
        else if (dg) q = R_EXPD;
      end
      R_EXPS, R_EXPD: begin
        if (dg) q = R_EXPD;
      end
      R_HX: begin
        if (hex_char(c))   q = R_HINT;
        else if (c == ".") q = R_HDOTN;
      end
      R_HINT: begin
        if (hex_char(c))    q = R_HINT;
        else if (c == ".")  q = R_HFRAC;
        else if (lc == "p") q = R_HP;
      end
      R_HDOTN: begin
        if (hex_char(c)) q = R_HFRAC;
      end
      R_HFRAC: begin
        if (hex_char(c))    q = R_HFRAC;
        else if (lc == "p") q = R_HP;
      end
      R_HP: begin
        if (sg)      q = R_HPS;
        else if (dg) q = R_HPD;
      end
      R_HPS, R_HPD: begin
        if (dg) q = R_HPD;
      end
      R_I:       if (lc == "n") q = R_IN;
      R_IN:      if (lc == "f") q = R_INF;
      R_INF:     if (lc == "i") q = R_INFI;
      R_INFI:    if (lc == "n") q = R_INFIN;
      R_INFIN:   if (lc == "i") q = R_INFINI;
      R_INFINI:  if (lc == "t") q = R_INFINIT;
      R_INFINIT: if (lc == "y") q = R_INFINITY;
      R_N:       if (lc == "a") q = R_NA;
      R_NA:      if (lc == "n") q = R_NAN;
      default:   q = R_DEAD;
    endcase
    return q;
  endfunction

  function automatic void emit(ev_e e, logic [7:0] ch, cls_e k);
    lex_event_t x;
    x.ev   = e;
    x.ch   = ch;
    x.cls  = k;
    x.last = 1'b0;
    run_buf.push_back(x);
  endfunction

  // advance the lexer by one source byte and queue the events it causes
  function automatic void lex_byte(logic [7:0] c);
    logic is_br;
    cls_e k;
    is_br = delim_bracket(c);
    case (lex_mode)
      MODE_ATOM: begin
        if (c == CH_NUL || blank_char(c) || is_br || c == CH_SEMI) begin
          k = numeral_complete(num_pos) ? CLS_NUM : CLS_SYM;
          emit(EV_TEND, CH_NUL, k);
          num_pos  = R_START;
          lex_mode = (c == CH_SEMI) ? MODE_CMT : MODE_IDLE;
          if (is_br) emit(bracket_code_of(c), CH_NUL, CLS_NUM);
          if (c == CH_NUL) emit(EV_EOF, CH_NUL, CLS_NUM);
        end else begin
          num_pos = numeral_advance(num_pos, c);
          emit(EV_VALUE, c, CLS_NUM);
        end
      end
      MODE_STR: begin
        if (c == CH_NUL) begin
          emit(EV_TEND, CH_NUL, CLS_STR);
          emit(EV_EOF, CH_NUL, CLS_NUM);
          lex_mode = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          emit(EV_TEND, CH_NUL, CLS_STR);
          lex_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          lex_mode = MODE_ESC;
        end else begin
          emit(EV_VALUE, c, CLS_NUM);
        end
      end
      MODE_ESC: begin
        if (c == CH_NUL) begin
          // dangling backslash comes out as itself
          emit(EV_VALUE, CH_BSLASH, CLS_NUM);
          emit(EV_TEND, CH_NUL, CLS_STR);
          emit(EV_EOF, CH_NUL, CLS_NUM);
          lex_mode = MODE_IDLE;
        end else begin
          if (c == CH_LC_N)      emit(EV_VALUE, CH_LF, CLS_NUM);
          else if (c == CH_LC_T) emit(EV_VALUE, CH_TAB, CLS_NUM);
          else                   emit(EV_VALUE, c, CLS_NUM);
          lex_mode = MODE_STR;
        end
      end
      MODE_CMT: begin
        if (c == CH_NUL) begin
          emit(EV_EOF, CH_NUL, CLS_NUM);
          lex_mode = MODE_IDLE;
        end else if (c == CH_LF) begin
          lex_mode = MODE_IDLE;
        end
      end
      default: begin
        lex_mode = MODE_IDLE;
        num_pos  = R_START;
        if (c == CH_NUL) begin
          emit(EV_EOF, CH_NUL, CLS_NUM);
        end else if (blank_char(c)) begin
        end else if (c == CH_SEMI) begin
          lex_mode = MODE_CMT;
        end else if (is_br) begin
          emit(bracket_code_of(c), CH_NUL, CLS_NUM);
        end else if (c == CH_QUOTE) begin
          lex_mode = MODE_STR;
        end else begin
          num_pos = numeral_advance(R_START, c);
          emit(EV_VALUE, c, CLS_NUM);
          lex_mode = MODE_ATOM;
        end
      end
    endcase
    if (run_buf.size() > 0) run_buf[run_buf.size() - 1].last = 1'b1;
    while (run_buf.size() > 0) awaited_events.push_back(run_buf.pop_front());
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_events.delete();
      run_buf.delete();
      lex_mode   = MODE_IDLE;
      num_pos    = R_START;
      fails      = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // results belong to earlier bytes: check before predicting this edge's byte
      if (out_valid_i && !out_stall_i) begin
        if (awaited_events.size() == 0) begin
          $display("%0t: unexpected event: actual ev=%0d ch=%02h cls=%0d last=%0b",
                   $time, event_res_i, value_char_i, token_class_i, last_of_run_i);
          fails++;
        end else begin
          head = awaited_events.pop_front();
          if (head.ev !== event_res_i || head.ch !== value_char_i ||
              head.cls !== token_class_i || head.last !== last_of_run_i) begin
            $display("%0t: event mismatch: expected ev=%0d ch=%02h cls=%0d last=%0b",
                     $time, head.ev, head.ch, head.cls, head.last);
            $display("%0t:                 actual   ev=%0d ch=%02h cls=%0d last=%0b",
                     $time, event_res_i, value_char_i, token_class_i, last_of_run_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) lex_byte(source_byte_i);
      pending_o  <= awaited_events.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sexp_tok_pkg::*;

  localparam int SOURCE_ITEMS = 350;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] source_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] event_res;
  logic [7:0] value_char;
  logic [1:0] token_class;
  logic       last_of_run;
  int         fail_cnt;
  int         pending;

  logic [7:0] src_fifo[$];
  int         sent;
  int         quiet;
  bit         hold_req;
  bit         no_idle;
  bit         held;
  bit         paused;

  s_expression_tokenizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .source_byte_i (source_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_res_o   (event_res),
    .value_char_o  (value_char),
    .token_class_o (token_class),
    .last_of_run_o (last_of_run)
  );

  sexp_tok_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .source_byte_i (source_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .event_res_i   (event_res),
    .value_char_i  (value_char),
    .token_class_i (token_class),
    .last_of_run_i (last_of_run),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------- source generation ----------------

  function automatic logic atom_breaker(logic [7:0] c);
    return c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D) ||
           c == CH_SEMI || c == "(" || c == ")" || c == "[" || c == "]" ||
           c == "{" || c == "}";
  endfunction

  function automatic logic [7:0] rand_atom_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (atom_breaker(c));
    return c;
  endfunction

  function automatic logic [7:0] cased(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 0) return 8'(c - 8'd32);
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return cased(8'("a" + v - 10));
  endfunction

  function automatic logic [7:0] rand_blank();
    int w;
    w = $urandom_range(8, 13);
    return (w == 8) ? CH_SPACE : 8'(w);
  endfunction

  function automatic logic [7:0] rand_bracket();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = "(";
      1:       c = ")";
      2:       c = "[";
      3:       c = "]";
      4:       c = "{";
      default: c = "}";
    endcase
    return c;
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) src_fifo.push_back(8'(s[i]));
  endfunction

  // exponent marker, optional sign, zero to three digits (zero leaves it open)
  function automatic void add_exponent(logic [7:0] marker);
    int s;
    src_fifo.push_back(cased(marker));
    s = $urandom_range(0, 2);
    if (s == 0) src_fifo.push_back("+");
    if (s == 1) src_fifo.push_back("-");
    repeat ($urandom_range(0, 3)) src_fifo.push_back(rand_digit());
  endfunction

  function automatic void add_word_prefix(string w, int n);
    for (int i = 0; i < n; i++) src_fifo.push_back(cased(8'(w[i])));
  endfunction

  function automatic void add_number();
    int s;
    int n;
    s = $urandom_range(0, 3);
    if (s == 0) src_fifo.push_back("+");
    if (s == 1) src_fifo.push_back("-");
    case ($urandom_range(0, 4))
      0: begin
        repeat ($urandom_range(0, 4)) src_fifo.push_back(rand_digit());
        if ($urandom_range(0, 1) == 0) begin
          src_fifo.push_back(".");
          repeat ($urandom_range(0, 3)) src_fifo.push_back(rand_digit());
        end
        if ($urandom_range(0, 2) == 0) add_exponent("e");
      end
      1: begin
        src_fifo.push_back("0");
        src_fifo.push_back(cased("x"));
        repeat ($urandom_range(0, 4)) src_fifo.push_back(rand_hex_digit());
        if ($urandom_range(0, 1) == 0) begin
          src_fifo.push_back(".");
          repeat ($urandom_range(0, 3)) src_fifo.push_back(rand_hex_digit());
        end
        if ($urandom_range(0, 1) == 0) add_exponent("p");
      end
      2: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) :
            (($urandom_range(0, 1) == 0) ? 3 : 8);
        add_word_prefix("infinity", n);
      end
      3: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 3;
        add_word_prefix("nan", n);
      end
      default: begin
        src_fifo.push_back("0");
        repeat ($urandom_range(0, 3)) src_fifo.push_back(rand_digit());
        if ($urandom_range(0, 2) == 0) add_exponent("e");
      end
    endcase
    // spoil the number now and then
    if ($urandom_range(0, 7) == 0) src_fifo.push_back(rand_atom_char());
  endfunction

  function automatic void add_symbol();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = cased(8'("a" + $urandom_range(0, 25)));
    end else begin
      do c = rand_atom_char(); while (c == CH_QUOTE);
    end
    src_fifo.push_back(c);
    repeat ($urandom_range(0, 5)) src_fifo.push_back(rand_atom_char());
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    int         e;
    src_fifo.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        src_fifo.push_back(CH_BSLASH);
        case ($urandom_range(0, 4))
          0:       src_fifo.push_back(CH_LC_N);
          1:       src_fifo.push_back(CH_LC_T);
          2:       src_fifo.push_back(CH_QUOTE);
          3:       src_fifo.push_back(CH_BSLASH);
          default: src_fifo.push_back(8'($urandom_range(1, 255)));
        endcase
      end else begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        src_fifo.push_back(c);
      end
    end
    e = $urandom_range(0, 19);
    if (e == 0) begin
      src_fifo.push_back(CH_NUL);
    end else if (e == 1) begin
      src_fifo.push_back(CH_BSLASH);
      src_fifo.push_back(CH_NUL);
    end else begin
      src_fifo.push_back(CH_QUOTE);
    end
  endfunction

  function automatic void add_comment();
    logic [7:0] c;
    src_fifo.push_back(CH_SEMI);
    repeat ($urandom_range(0, 5)) begin
      do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
      src_fifo.push_back(c);
    end
    src_fifo.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_LF);
  endfunction

  function automatic void add_random_token();
    int k;
    int s;
    k = $urandom_range(0, 99);
    if (k < 30)      add_number();
    else if (k < 45) add_symbol();
    else if (k < 65) add_string();
    else if (k < 75) src_fifo.push_back(rand_bracket());
    else if (k < 83) add_comment();
    else if (k < 94) src_fifo.push_back(8'($urandom_range(0, 255)));
    else             src_fifo.push_back(CH_NUL);
    s = $urandom_range(0, 9);
    if (k < 45) begin
      // atoms need a terminator; leave one out now and then
      if (s < 6)       src_fifo.push_back(rand_blank());
      else if (s < 8)  src_fifo.push_back(rand_bracket());
      else if (s == 8) add_comment();
    end else if (s < 5) begin
      src_fifo.push_back(rand_blank());
    end
  endfunction

  // ---------------- drivers ----------------

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic flush_src();
    while (src_fifo.size() > 0) send_byte(src_fifo.pop_front());
  endtask

  initial begin
    int w;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills and stalls its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    source_byte = 8'h00;
    hold_req    = 1'b0;
    no_idle     = 1'b0;
    held        = 1'b0;
    paused      = 1'b0;
    sent        = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // brackets, number and symbol ends, escapes, empty string, comment,
    // end of source inside a string after a backslash, a comment and an atom
    add_text("(1)[]{");
    src_fifo.push_back(8'hFF);
    add_text("}\"\\n\\t\"\"\";x\n\"\\");
    src_fifo.push_back(CH_NUL);
    add_text(";");
    src_fifo.push_back(CH_NUL);
    add_text("x");
    src_fifo.push_back(CH_NUL);
    flush_src();

    while (sent < SOURCE_ITEMS) begin
      if (!held && sent >= 120) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 240) begin
        // drain everything before going on
        paused   = 1'b1;
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      no_idle = (sent >= 60 && sent < 100) || (sent >= 280 && sent < 310);
      add_random_token();
      flush_src();
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/sexp_tok_pkg.sv
hdl/sexp_tok_front.sv
hdl/sexp_tok_queue.sv
hdl/sexp_tok_back.sv
hdl/s_expression_tokenizer.sv
tb/sv/sexp_tok_checker.sv
tb/sv/tb_top.sv
